/* sv/uycd_pkg.sv */
`default_nettype none

package uycd_pkg;

    // Source raster defaults
    localparam int SRC_WIDTH_DEF  = 640;
    localparam int SRC_HEIGHT_DEF = 480;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int DIM_W   = 9;
    localparam int STEP_W  = 9;
    localparam int CROP_W  = 10;
    localparam int RGB_W   = 16;
    localparam int CFG_W   = 10;
    localparam int CFG_IDX_W = 2;

    // One quad carries two pixels
    localparam int LANES = 2;

    // Register reset values
    localparam logic [DIM_W-1:0]  OUT_WIDTH_RST   = 9'd160;
    localparam logic [DIM_W-1:0]  OUT_HEIGHT_RST  = 9'd160;
    localparam logic [STEP_W-1:0] SAMPLE_STEP_RST = 9'd3;
    localparam logic [CROP_W-1:0] CROP_LEFT_RST   = 10'd80;

    // Fixed-point conversion
    localparam int SUM_W = 20;
    localparam logic [BYTE_W-1:0]       LUMA_OFS   = 8'd16;
    localparam logic signed [SUM_W-1:0] CHROMA_OFS = 20'sd128;
    localparam logic signed [SUM_W-1:0] COEF_Y     = 20'sd298;
    localparam logic signed [SUM_W-1:0] COEF_RV    = 20'sd409;
    localparam logic signed [SUM_W-1:0] COEF_GU    = 20'sd100;
    localparam logic signed [SUM_W-1:0] COEF_GV    = 20'sd208;
    localparam logic signed [SUM_W-1:0] COEF_BU    = 20'sd516;
    localparam logic signed [SUM_W-1:0] ROUND      = 20'sd128;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OUT_WIDTH   = 2'd0,
        REG_OUT_HEIGHT  = 2'd1,
        REG_SAMPLE_STEP = 2'd2,
        REG_CROP_LEFT   = 2'd3
    } cfg_idx_e;

    typedef struct packed {
        logic [DIM_W-1:0]  out_width;
        logic [DIM_W-1:0]  out_height;
        logic [STEP_W-1:0] sample_step;
        logic [CROP_W-1:0] crop_left;
    } cfg_t;

    // Sampled pixel on its way into a conversion lane
    typedef struct packed {
        logic              emit;
        logic              row_end;
        logic              frame_end;
        logic [BYTE_W-1:0] luma;
        logic [BYTE_W-1:0] cu;
        logic [BYTE_W-1:0] cv;
    } lane_in_t;

    // Converted pixel leaving a lane
    typedef struct packed {
        logic             emit;
        logic             row_end;
        logic             frame_end;
        logic [RGB_W-1:0] rgb;
    } pix_t;

endpackage

`default_nettype wire

/* sv/uycd_if.sv */
`default_nettype none

interface uycd_yuv_if;
    logic                        valid;
    logic                        ready;
    logic [uycd_pkg::BYTE_W-1:0] chroma_u;
    logic [uycd_pkg::BYTE_W-1:0] luma_even;
    logic [uycd_pkg::BYTE_W-1:0] chroma_v;
    logic [uycd_pkg::BYTE_W-1:0] luma_odd;
    logic                        frame_start;

    modport source (
        output valid, chroma_u, luma_even, chroma_v, luma_odd, frame_start,
        input  ready
    );
    modport sink (
        input  valid, chroma_u, luma_even, chroma_v, luma_odd, frame_start,
        output ready
    );
endinterface

interface uycd_rgb_if;
    logic                       valid;
    logic                       ready;
    logic [uycd_pkg::RGB_W-1:0] rgb565;
    logic                       row_end;
    logic                       frame_end;

    modport source (
        output valid, rgb565, row_end, frame_end,
        input  ready
    );
    modport sink (
        input  valid, rgb565, row_end, frame_end,
        output ready
    );
endinterface

`default_nettype wire

/* sv/uycd_ctrl.sv */
`default_nettype none

module uycd_ctrl #(
    parameter int SRC_WIDTH  = uycd_pkg::SRC_WIDTH_DEF,
    parameter int SRC_HEIGHT = uycd_pkg::SRC_HEIGHT_DEF
) (
    input  wire                                          clk,
    input  wire                                          rst_n,
    input  uycd_pkg::cfg_t                               cfg,
    input  wire                                          adv,
    input  wire                                          fire,
    input  wire                                          frame_start,
    input  wire  [uycd_pkg::BYTE_W-1:0]                  chroma_u,
    input  wire  [uycd_pkg::BYTE_W-1:0]                  luma_even,
    input  wire  [uycd_pkg::BYTE_W-1:0]                  chroma_v,
    input  wire  [uycd_pkg::BYTE_W-1:0]                  luma_odd,
    output uycd_pkg::lane_in_t [uycd_pkg::LANES-1:0]     lanes
);

    localparam int QUADS  = (SRC_WIDTH + 1) / 2;
    localparam int QC_W   = (QUADS > 1) ? $clog2(QUADS) : 1;
    localparam int X_W    = QC_W + 1;
    localparam int SR_W   = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;
    localparam int NSC_W  = $clog2(SRC_WIDTH + (1 << uycd_pkg::CROP_W));
    localparam int NSR_W  = $clog2(SRC_HEIGHT + (1 << uycd_pkg::STEP_W));
    localparam int PROD_W = uycd_pkg::STEP_W + uycd_pkg::DIM_W;
    localparam int DIM_W  = uycd_pkg::DIM_W;
    localparam int CNT_W  = DIM_W + 1;

    localparam logic [QC_W-1:0]  QC_LAST = QC_W'(QUADS - 1);
    localparam logic [SR_W-1:0]  SR_LAST = SR_W'(SRC_HEIGHT - 1);
    localparam logic [X_W:0]     X_LIMIT = (X_W + 1)'(SRC_WIDTH);
    localparam logic [PROD_W-1:0] H_LIMIT = PROD_W'(SRC_HEIGHT);

    logic [QC_W-1:0]  qc_reg,  qc_next;
    logic [SR_W-1:0]  sr_reg,  sr_next;
    logic [DIM_W-1:0] oc_reg,  oc_next;
    logic [DIM_W-1:0] or_reg,  or_next;
    logic [NSC_W-1:0] nsc_reg, nsc_next;
    logic [NSR_W-1:0] nsr_reg, nsr_next;

    logic [QC_W-1:0]  qc_c;
    logic [SR_W-1:0]  sr_c;
    logic [DIM_W-1:0] oc_c;
    logic [DIM_W-1:0] or_c;
    logic [NSC_W-1:0] nsc_c, nsc1, step_c;
    logic [NSR_W-1:0] nsr_c;
    logic [X_W-1:0]   x0, x1;
    logic [CNT_W-1:0] oc_w, oc1, width_w;
    logic             enabled, row_on, last_row, x1_in;
    logic             e0, e1, re0, re1;
    logic [PROD_W-1:0] area;

    uycd_pkg::lane_in_t [uycd_pkg::LANES-1:0] lanes_reg, lanes_next;

    // Take the counters as restarted when the quad opens a frame
    always_comb
    begin
        qc_c  = frame_start ? '0 : qc_reg;
        sr_c  = frame_start ? '0 : sr_reg;
        oc_c  = frame_start ? '0 : oc_reg;
        or_c  = frame_start ? '0 : or_reg;
        nsc_c = frame_start ? NSC_W'(cfg.crop_left) : nsc_reg;
        nsr_c = frame_start ? '0 : nsr_reg;
    end

    // Decide which of the two pixels are sampled
    always_comb
    begin
        step_c   = NSC_W'(cfg.sample_step);
        area     = PROD_W'(cfg.sample_step) * PROD_W'(cfg.out_height);
        enabled  = (cfg.sample_step != '0) && (area <= H_LIMIT);
        row_on   = enabled && (or_c < cfg.out_height) && (NSR_W'(sr_c) == nsr_c);
        last_row = ({1'b0, or_c} + CNT_W'(1)) == {1'b0, cfg.out_height};
        width_w  = {1'b0, cfg.out_width};
        x0       = {qc_c, 1'b0};
        x1       = {qc_c, 1'b1};
        x1_in    = {1'b0, x1} < X_LIMIT;
        oc_w     = {1'b0, oc_c};

        e0   = row_on && (oc_w < width_w) && (NSC_W'(x0) == nsc_c);
        re0  = (oc_w + CNT_W'(1)) == width_w;
        oc1  = oc_w + CNT_W'(e0);
        nsc1 = e0 ? nsc_c + step_c : nsc_c;
        e1   = row_on && x1_in && (oc1 < width_w) && (NSC_W'(x1) == nsc1);
        re1  = (oc1 + CNT_W'(1)) == width_w;
    end

    // Advance the raster position
    always_comb
    begin
        qc_next  = qc_c + QC_W'(1);
        sr_next  = sr_c;
        oc_next  = oc1[DIM_W-1:0] + DIM_W'(e1);
        or_next  = or_c;
        nsc_next = e1 ? nsc1 + step_c : nsc1;
        nsr_next = nsr_c;
        if (qc_c == QC_LAST)
        begin
            qc_next  = '0;
            oc_next  = '0;
            nsc_next = NSC_W'(cfg.crop_left);
            if (sr_c == SR_LAST)
            begin
                sr_next  = '0;
                or_next  = '0;
                nsr_next = '0;
            end
            else
            begin
                sr_next  = sr_c + SR_W'(1);
                or_next  = or_c + DIM_W'(row_on);
                nsr_next = row_on ? nsr_c + NSR_W'(cfg.sample_step) : nsr_c;
            end
        end
    end

    // Build the lane requests
    always_comb
    begin
        lanes_next[0].emit      = fire && e0;
        lanes_next[0].row_end   = re0;
        lanes_next[0].frame_end = re0 && last_row;
        lanes_next[0].luma      = luma_even;
        lanes_next[0].cu        = chroma_u;
        lanes_next[0].cv        = chroma_v;
        lanes_next[1].emit      = fire && e1;
        lanes_next[1].row_end   = re1;
        lanes_next[1].frame_end = re1 && last_row;
        lanes_next[1].luma      = luma_odd;
        lanes_next[1].cu        = chroma_u;
        lanes_next[1].cv        = chroma_v;
    end

    // Hold position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qc_reg  <= '0;
            sr_reg  <= '0;
            oc_reg  <= '0;
            or_reg  <= '0;
            nsc_reg <= NSC_W'(uycd_pkg::CROP_LEFT_RST);
            nsr_reg <= '0;
        end
        else if (fire)
        begin
            qc_reg  <= qc_next;
            sr_reg  <= sr_next;
            oc_reg  <= oc_next;
            or_reg  <= or_next;
            nsc_reg <= nsc_next;
            nsr_reg <= nsr_next;
        end
    end

    // Register the lane requests
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lanes_reg <= '0;
        end
        else if (adv)
        begin
            lanes_reg <= lanes_next;
        end
    end

    assign lanes = lanes_reg;

endmodule

`default_nettype wire

/* sv/uycd_lane.sv */
`default_nettype none

module uycd_lane (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 adv,
    input  uycd_pkg::lane_in_t  lin,
    output uycd_pkg::pix_t      pout
);

    localparam int SUM_W  = uycd_pkg::SUM_W;
    localparam int BYTE_W = uycd_pkg::BYTE_W;

    function automatic logic [BYTE_W-1:0] sat8(input logic signed [SUM_W-1:0] t);
        logic [BYTE_W-1:0] res;
        begin
            if (t[SUM_W-1])
                res = '0;
            else if (t[SUM_W-2:2*BYTE_W] != '0)
                res = '1;
            else
                res = t[2*BYTE_W-1:BYTE_W];
            return res;
        end
    endfunction

    logic [BYTE_W-1:0]       yc;
    logic signed [SUM_W-1:0] ys, us, vs;
    logic signed [SUM_W-1:0] py_next, prv_next, pgu_next, pgv_next, pbu_next;
    logic signed [SUM_W-1:0] py_reg, prv_reg, pgu_reg, pgv_reg, pbu_reg;
    logic signed [SUM_W-1:0] r_sum, g_sum, b_sum;
    logic [BYTE_W-1:0]       r8, g8, b8;
    logic                    emit_reg, row_end_reg, frame_end_reg;
    uycd_pkg::pix_t          pout_reg, pout_next;

    // Remove offsets and form the coefficient products
    always_comb
    begin
        yc = (lin.luma > uycd_pkg::LUMA_OFS) ? lin.luma - uycd_pkg::LUMA_OFS : '0;
        ys = $signed({{(SUM_W - BYTE_W){1'b0}}, yc});
        us = $signed({{(SUM_W - BYTE_W){1'b0}}, lin.cu}) - uycd_pkg::CHROMA_OFS;
        vs = $signed({{(SUM_W - BYTE_W){1'b0}}, lin.cv}) - uycd_pkg::CHROMA_OFS;
        py_next  = ys * uycd_pkg::COEF_Y;
        prv_next = vs * uycd_pkg::COEF_RV;
        pgu_next = us * uycd_pkg::COEF_GU;
        pgv_next = vs * uycd_pkg::COEF_GV;
        pbu_next = us * uycd_pkg::COEF_BU;
    end

    // Sum, saturate and pack
    always_comb
    begin
        r_sum = py_reg + prv_reg + uycd_pkg::ROUND;
        g_sum = py_reg - pgu_reg - pgv_reg + uycd_pkg::ROUND;
        b_sum = py_reg + pbu_reg + uycd_pkg::ROUND;
        r8    = sat8(r_sum);
        g8    = sat8(g_sum);
        b8    = sat8(b_sum);
        pout_next.emit      = emit_reg;
        pout_next.row_end   = row_end_reg;
        pout_next.frame_end = frame_end_reg;
        pout_next.rgb       = {r8[7:3], g8[7:2], b8[7:3]};
    end

    // Hold the product stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            py_reg        <= py_next;
            prv_reg       <= prv_next;
            pgu_reg       <= pgu_next;
            pgv_reg       <= pgv_next;
            pbu_reg       <= pbu_next;
            row_end_reg   <= lin.row_end;
            frame_end_reg <= lin.frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_reg <= 1'b0;
        end
        else if (adv)
        begin
            emit_reg <= lin.emit;
        end
    end

    // Hold the packed pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pout_reg <= '0;
        end
        else if (adv)
        begin
            pout_reg <= pout_next;
        end
    end

    assign pout = pout_reg;

endmodule

`default_nettype wire

/* sv/uycd_merge.sv */
`default_nettype none

module uycd_merge (
    input  wire                                      clk,
    input  wire                                      rst_n,
    input  uycd_pkg::pix_t [uycd_pkg::LANES-1:0]     pix,
    output logic                                     adv,
    uycd_rgb_if.source                               rgb
);

    logic [1:0]     cnt_reg, cnt_next;
    uycd_pkg::pix_t slot0_reg, slot0_next;
    uycd_pkg::pix_t slot1_reg, slot1_next;
    logic           out_fire;

    // Advance the pipeline once the held pair is gone or leaving
    assign adv      = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && rgb.ready);
    assign out_fire = (cnt_reg != 2'd0) && rgb.ready;

    // Load a new pair, packed to the front, or shift out one request
    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (adv)
        begin
            slot1_next = pix[1];
            if (pix[0].emit)
            begin
                slot0_next = pix[0];
                cnt_next   = pix[1].emit ? 2'd2 : 2'd1;
            end
            else
            begin
                slot0_next = pix[1];
                cnt_next   = pix[1].emit ? 2'd1 : 2'd0;
            end
        end
        else if (out_fire)
        begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign rgb.valid     = cnt_reg != 2'd0;
    assign rgb.rgb565    = slot0_reg.rgb;
    assign rgb.row_end   = slot0_reg.row_end;
    assign rgb.frame_end = slot0_reg.frame_end;

endmodule

`default_nettype wire

/* sv/uyvy_crop_decimate_to_rgb565.sv */
// Path: lane request, product stage, packed pixel and output pair registers.
// Throughput: one quad per cycle while rgb is ready; a quad with both pixels
//   sampled (sample_step of 1) stalls the next until its first pixel leaves rgb.
// Reset: rst_n clears position counters and emit flags, empties the output pair
//   and loads the register defaults (160 x 160, step 3, crop at column 80).
`default_nettype none

module uyvy_crop_decimate_to_rgb565 #(
    parameter int SRC_WIDTH  = uycd_pkg::SRC_WIDTH_DEF,
    parameter int SRC_HEIGHT = uycd_pkg::SRC_HEIGHT_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    uycd_yuv_if.sink                          yuv,
    uycd_rgb_if.source                        rgb,
    input  wire                               cfg_we,
    input  wire  [uycd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [uycd_pkg::CFG_W-1:0]        cfg_data
);

    uycd_pkg::cfg_t                           cfg_reg;
    uycd_pkg::lane_in_t [uycd_pkg::LANES-1:0] lanes;
    uycd_pkg::pix_t     [uycd_pkg::LANES-1:0] pix;
    logic                                     adv;
    logic                                     fire;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.out_width   <= uycd_pkg::OUT_WIDTH_RST;
            cfg_reg.out_height  <= uycd_pkg::OUT_HEIGHT_RST;
            cfg_reg.sample_step <= uycd_pkg::SAMPLE_STEP_RST;
            cfg_reg.crop_left   <= uycd_pkg::CROP_LEFT_RST;
        end
        else if (cfg_we)
        begin
            case (uycd_pkg::cfg_idx_e'(cfg_index))
                uycd_pkg::REG_OUT_WIDTH:
                    cfg_reg.out_width   <= cfg_data[uycd_pkg::DIM_W-1:0];
                uycd_pkg::REG_OUT_HEIGHT:
                    cfg_reg.out_height  <= cfg_data[uycd_pkg::DIM_W-1:0];
                uycd_pkg::REG_SAMPLE_STEP:
                    cfg_reg.sample_step <= cfg_data[uycd_pkg::STEP_W-1:0];
                uycd_pkg::REG_CROP_LEFT:
                    cfg_reg.crop_left   <= cfg_data[uycd_pkg::CROP_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Accept a quad whenever the pipeline moves
    assign yuv.ready = adv;
    assign fire      = yuv.valid && adv;

    uycd_ctrl #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .adv         (adv),
        .fire        (fire),
        .frame_start (yuv.frame_start),
        .chroma_u    (yuv.chroma_u),
        .luma_even   (yuv.luma_even),
        .chroma_v    (yuv.chroma_v),
        .luma_odd    (yuv.luma_odd),
        .lanes       (lanes)
    );

    // Convert both pixels of the quad side by side
    for (genvar i = 0; i < uycd_pkg::LANES; i++)
    begin : g_lane
        uycd_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .lin   (lanes[i]),
            .pout  (pix[i])
        );
    end

    uycd_merge u_merge (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix),
        .adv   (adv),
        .rgb   (rgb)
    );

endmodule

`default_nettype wire
